// ----- sv/ctsq_pkg.sv -----
// ctsq_pkg: shared types, constants and helpers for the conveyor transfer sequencer
// used by ctsq_cfg_regs, ctsq_seq_core and conveyor_transfer_sequencer_top
// no dependencies

package ctsq_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_STOPPER_WAIT = 2'd0;
  localparam logic [1:0] CFG_RUNOUT       = 2'd1;
  localparam logic [1:0] CFG_OPEN_POS     = 2'd2;
  localparam logic [1:0] CFG_CLOSED_POS   = 2'd3;

  // configuration reset values
  localparam logic [7:0]  RST_STOPPER_WAIT = 8'd128;
  localparam logic [7:0]  RST_RUNOUT       = 8'd64;
  localparam logic [15:0] RST_OPEN_POS     = 16'd3000;
  localparam logic [15:0] RST_CLOSED_POS   = 16'd1000;

  // event counter wraps after this many events
  localparam logic [6:0] EVENT_MODULUS = 7'd100;
  localparam logic [7:0] TICK_MAX      = 8'd255;

  // sensor bit positions
  localparam logic [2:0] SNS_DROP_AGV   = 3'd0;
  localparam logic [2:0] SNS_DROP_STAGE = 3'd1;
  localparam logic [2:0] SNS_BUFFER     = 3'd2;
  localparam logic [2:0] SNS_PICK_STAGE = 3'd3;
  localparam logic [2:0] SNS_PICK_AGV   = 3'd4;

  // command codes
  localparam logic [1:0] REQ_NONE   = 2'd0;
  localparam logic [1:0] REQ_AUTO   = 2'd1;
  localparam logic [1:0] REQ_MANUAL = 2'd2;
  localparam logic [1:0] REQ_STATUS = 2'd3;

  // stream widths
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 40;

  // transfer sequence steps
  typedef enum logic [7:0] {
    STEP_IDLE        = 8'b0000_0001,
    STEP_WAIT_DROP   = 8'b0000_0010,
    STEP_TO_BUFFER   = 8'b0000_0100,
    STEP_WAIT_PICK   = 8'b0000_1000,
    STEP_STOPPER     = 8'b0001_0000,
    STEP_TRANSFER    = 8'b0010_0000,
    STEP_PICK_ARRIVE = 8'b0100_0000,
    STEP_PICK_READY  = 8'b1000_0000
  } ctsq_step_t;

  typedef struct packed {
    logic [7:0]  stopper_wait_ticks;
    logic [7:0]  conveyor_runout_ticks;
    logic [15:0] stopper_open_position;
    logic [15:0] stopper_closed_position;
  } ctsq_cfg_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       timer_tick;
    logic [4:0] sensor_bits;
  } ctsq_item_t;

  typedef struct packed {
    logic       reply_flag;
    logic [6:0] event_number;
    logic       event_flag;
    logic       pick_rdy_flag;
    logic       drop_rdy_flag;
    logic [15:0] stopper_position;
    logic       stopper_is_open;
    logic       pick_motor_on;
    logic       drop_motor_on;
    logic [2:0] step;
  } ctsq_result_t;

  // dense step number for the status word
  function automatic logic [2:0] step_code(input ctsq_step_t s);
    logic [2:0] c;
    case (s)
      STEP_IDLE:        c = 3'd0;
      STEP_WAIT_DROP:   c = 3'd1;
      STEP_TO_BUFFER:   c = 3'd2;
      STEP_WAIT_PICK:   c = 3'd3;
      STEP_STOPPER:     c = 3'd4;
      STEP_TRANSFER:    c = 3'd5;
      STEP_PICK_ARRIVE: c = 3'd6;
      STEP_PICK_READY:  c = 3'd7;
      default:          c = 3'd0;
    endcase
    return c;
  endfunction

endpackage

// ----- sv/ctsq_cfg_regs.sv -----
// ctsq_cfg_regs: configuration register file of the conveyor transfer sequencer
// depends on ctsq_pkg

module ctsq_cfg_regs (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [1:0]           wr_index,
  input  logic [15:0]          wr_data,
  output ctsq_pkg::ctsq_cfg_t  cfg
);

  ctsq_pkg::ctsq_cfg_t cfg_r;
  ctsq_pkg::ctsq_cfg_t cfg_nxt;

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        ctsq_pkg::CFG_STOPPER_WAIT: cfg_nxt.stopper_wait_ticks      = wr_data[7:0];
        ctsq_pkg::CFG_RUNOUT:       cfg_nxt.conveyor_runout_ticks   = wr_data[7:0];
        ctsq_pkg::CFG_OPEN_POS:     cfg_nxt.stopper_open_position   = wr_data;
        ctsq_pkg::CFG_CLOSED_POS:   cfg_nxt.stopper_closed_position = wr_data;
        default:                    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stopper_wait_ticks      <= ctsq_pkg::RST_STOPPER_WAIT;
      cfg_r.conveyor_runout_ticks   <= ctsq_pkg::RST_RUNOUT;
      cfg_r.stopper_open_position   <= ctsq_pkg::RST_OPEN_POS;
      cfg_r.stopper_closed_position <= ctsq_pkg::RST_CLOSED_POS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- sv/ctsq_seq_core.sv -----
// ctsq_seq_core: sequencer state and next-state logic, one control pass per advance
// depends on ctsq_pkg

module ctsq_seq_core (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  ctsq_pkg::ctsq_item_t    item,
  input  ctsq_pkg::ctsq_cfg_t     cfg,
  output ctsq_pkg::ctsq_result_t  res
);

  ctsq_pkg::ctsq_step_t step_r, step_nxt;
  logic        auto_r, auto_nxt;
  logic        drop_motor_r, drop_motor_nxt;
  logic        pick_motor_r, pick_motor_nxt;
  logic        stop_open_r, stop_open_nxt;
  logic [15:0] stop_pos_r, stop_pos_nxt;
  logic        drop_rdy_r, drop_rdy_nxt;
  logic        pick_rdy_r, pick_rdy_nxt;
  logic [7:0]  ticks_r, ticks_nxt;
  logic [4:0]  prev_snap_r;
  logic        snap_valid_r;
  logic [6:0]  ev_cnt_r, ev_cnt_nxt;

  logic        drop_agv, drop_stage, buffer_hi, pick_stage, pick_agv;
  logic [4:0]  snap;
  logic        ev;
  logic [7:0]  ticks_cnt;

  assign drop_agv   = item.sensor_bits[ctsq_pkg::SNS_DROP_AGV];
  assign drop_stage = item.sensor_bits[ctsq_pkg::SNS_DROP_STAGE];
  assign buffer_hi  = item.sensor_bits[ctsq_pkg::SNS_BUFFER];
  assign pick_stage = item.sensor_bits[ctsq_pkg::SNS_PICK_STAGE];
  assign pick_agv   = item.sensor_bits[ctsq_pkg::SNS_PICK_AGV];

  // snapshot and event detection
  assign snap = {stop_open_r, pick_rdy_r, drop_rdy_r, pick_motor_r, drop_motor_r};
  assign ev   = snap_valid_r && (snap != prev_snap_r);

  always_comb begin
    ev_cnt_nxt = ev_cnt_r;
    if (ev) begin
      if (ev_cnt_r == ctsq_pkg::EVENT_MODULUS - 7'd1) ev_cnt_nxt = 7'd0;
      else                                              ev_cnt_nxt = ev_cnt_r + 7'd1;
    end
  end

  // saturating tick count, taken at the start of the pass
  assign ticks_cnt = (item.timer_tick && ticks_r != ctsq_pkg::TICK_MAX) ?
                     ticks_r + 8'd1 : ticks_r;

  // mode command
  always_comb begin
    case (item.req_type)
      ctsq_pkg::REQ_AUTO:   auto_nxt = 1'b1;
      ctsq_pkg::REQ_MANUAL: auto_nxt = 1'b0;
      default:              auto_nxt = auto_r;
    endcase
  end

  // status word, taken before the sequence update
  always_comb begin
    res.step             = ctsq_pkg::step_code(step_r);
    res.drop_motor_on    = drop_motor_r;
    res.pick_motor_on    = pick_motor_r;
    res.stopper_is_open  = stop_open_r;
    res.stopper_position = stop_pos_r;
    res.drop_rdy_flag    = drop_rdy_r;
    res.pick_rdy_flag    = pick_rdy_r;
    res.event_flag       = ev;
    res.event_number     = ev ? ev_cnt_r : 7'd0;
    res.reply_flag       = item.req_type != ctsq_pkg::REQ_NONE;
  end

  // ready clearing and transfer sequence
  always_comb begin
    step_nxt       = step_r;
    drop_motor_nxt = drop_motor_r;
    pick_motor_nxt = pick_motor_r;
    stop_open_nxt  = stop_open_r;
    stop_pos_nxt   = stop_pos_r;
    ticks_nxt      = ticks_cnt;
    pick_rdy_nxt   = pick_rdy_r &&
                     !(pick_stage || !pick_agv || pick_motor_r || stop_open_r);
    drop_rdy_nxt   = drop_rdy_r &&
                     !(!drop_stage || drop_agv || drop_motor_r || stop_open_r);
    case (step_r)
      ctsq_pkg::STEP_IDLE: begin
        if (auto_nxt) step_nxt = ctsq_pkg::STEP_WAIT_DROP;
      end
      ctsq_pkg::STEP_WAIT_DROP: begin
        if (drop_stage && !drop_agv && !drop_motor_r && !stop_open_r)
          step_nxt = ctsq_pkg::STEP_TO_BUFFER;
      end
      ctsq_pkg::STEP_TO_BUFFER: begin
        if (!buffer_hi) begin
          drop_motor_nxt = 1'b1;
        end else begin
          drop_motor_nxt = 1'b0;
          step_nxt       = ctsq_pkg::STEP_WAIT_PICK;
        end
      end
      ctsq_pkg::STEP_WAIT_PICK: begin
        if (!pick_stage && !pick_agv) begin
          step_nxt  = ctsq_pkg::STEP_STOPPER;
          ticks_nxt = 8'd0;
        end
      end
      ctsq_pkg::STEP_STOPPER: begin
        stop_pos_nxt  = cfg.stopper_open_position;
        stop_open_nxt = 1'b1;
        if (ticks_cnt >= cfg.stopper_wait_ticks) step_nxt = ctsq_pkg::STEP_TRANSFER;
      end
      ctsq_pkg::STEP_TRANSFER: begin
        if (buffer_hi) begin
          drop_motor_nxt = 1'b1;
          pick_motor_nxt = 1'b1;
          ticks_nxt      = 8'd0;
        end else if (ticks_cnt >= cfg.conveyor_runout_ticks) begin
          drop_motor_nxt = 1'b0;
          stop_pos_nxt   = cfg.stopper_closed_position;
          stop_open_nxt  = 1'b0;
          drop_rdy_nxt   = 1'b1;
          step_nxt       = ctsq_pkg::STEP_PICK_ARRIVE;
        end
      end
      ctsq_pkg::STEP_PICK_ARRIVE: begin
        if (pick_stage) begin
          pick_motor_nxt = 1'b0;
          step_nxt       = ctsq_pkg::STEP_PICK_READY;
        end
      end
      ctsq_pkg::STEP_PICK_READY: begin
        pick_rdy_nxt = 1'b1;
        step_nxt     = ctsq_pkg::STEP_IDLE;
      end
      default: begin
        step_nxt = ctsq_pkg::STEP_IDLE;
      end
    endcase
  end

  // state registers, updated once per accepted pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r       <= ctsq_pkg::STEP_IDLE;
      auto_r       <= 1'b0;
      drop_motor_r <= 1'b0;
      pick_motor_r <= 1'b0;
      stop_open_r  <= 1'b0;
      stop_pos_r   <= ctsq_pkg::RST_CLOSED_POS;
      drop_rdy_r   <= 1'b0;
      pick_rdy_r   <= 1'b0;
      ticks_r      <= 8'd0;
      prev_snap_r  <= 5'd0;
      snap_valid_r <= 1'b0;
      ev_cnt_r     <= 7'd0;
    end else if (adv) begin
      step_r       <= step_nxt;
      auto_r       <= auto_nxt;
      drop_motor_r <= drop_motor_nxt;
      pick_motor_r <= pick_motor_nxt;
      stop_open_r  <= stop_open_nxt;
      stop_pos_r   <= stop_pos_nxt;
      drop_rdy_r   <= drop_rdy_nxt;
      pick_rdy_r   <= pick_rdy_nxt;
      ticks_r      <= ticks_nxt;
      prev_snap_r  <= snap;
      snap_valid_r <= 1'b1;
      ev_cnt_r     <= ev_cnt_nxt;
    end
  end

  // event counter never leaves its range
  a_ev_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    ev_cnt_r < ctsq_pkg::EVENT_MODULUS)
    else $error("event counter out of range");

  // stopper is only open while opening or transferring
  a_stop_open_step: assert property (@(posedge clk) disable iff (!rst_n)
    stop_open_r |-> (step_r == ctsq_pkg::STEP_STOPPER ||
                     step_r == ctsq_pkg::STEP_TRANSFER))
    else $error("stopper open outside transfer steps");

  // pick motor runs only from transfer until pick arrival
  a_pick_motor_step: assert property (@(posedge clk) disable iff (!rst_n)
    pick_motor_r |-> (step_r == ctsq_pkg::STEP_TRANSFER ||
                      step_r == ctsq_pkg::STEP_PICK_ARRIVE))
    else $error("pick motor on in wrong step");

  // drop motor runs only while filling the buffer or transferring
  a_drop_motor_step: assert property (@(posedge clk) disable iff (!rst_n)
    drop_motor_r |-> (step_r == ctsq_pkg::STEP_TO_BUFFER ||
                      step_r == ctsq_pkg::STEP_TRANSFER))
    else $error("drop motor on in wrong step");

  // no event is reported on the very first pass
  a_first_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && !snap_valid_r) |-> !res.event_flag)
    else $error("event flagged on first pass");

endmodule

// ----- sv/conveyor_transfer_sequencer_top.sv -----
// conveyor_transfer_sequencer_top: stream wrapper with input and result registers
// a word accepted into the input register is computed from it and shows on out_tvalid/out_tdata
//   once the result register takes it, held there while out_tready is low
// throughput: one word per cycle unless out_tready stalls; the sequencer state loop is a single registered pass
// reset: rst_n synchronous active low clears state, config to its defaults, both stages
// depends on ctsq_pkg, ctsq_cfg_regs, ctsq_seq_core

module conveyor_transfer_sequencer_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // sensor_bits[4:0], timer_tick[5], req_type[7:6]
  input  logic [ctsq_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // step[2:0], drop_motor_on[3], pick_motor_on[4], stopper_is_open[5],
  // stopper_position[21:6], drop_rdy_flag[22], pick_rdy_flag[23],
  // event_flag[24], event_number[31:25], reply_flag[32], zeros[39:33]
  output logic [ctsq_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [1:0]                          cfg_index,
  input  logic [15:0]                         cfg_data
);

  logic                   s1_valid_r;
  ctsq_pkg::ctsq_item_t   s1_item_r;
  logic                   out_valid_r;
  ctsq_pkg::ctsq_result_t out_res_r;
  logic                   adv;
  ctsq_pkg::ctsq_cfg_t    cfg;
  ctsq_pkg::ctsq_result_t res;

  // handshake control
  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;
  assign cfg_ready = 1'b1;

  ctsq_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  ctsq_seq_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .item  (s1_item_r),
    .cfg   (cfg),
    .res   (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_item_r <= ctsq_pkg::ctsq_item_t'(in_tdata);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_res_r};

endmodule

// ----- sim/conveyor_transfer_sequencer_top_tb.sv -----
// conveyor_transfer_sequencer_top_tb: self-checking bench for the conveyor transfer sequencer
// a directed walk through one full transfer, then random control passes under several settings,
// each status word checked against an in-bench model of the sequencer or a fixed word; depends on ctsq_pkg

module conveyor_transfer_sequencer_top_tb;

  // dense sequence step numbering as reported in the status word
  typedef enum logic [2:0] {
    ST_IDLE, ST_WAIT_DROP, ST_TO_BUFFER, ST_WAIT_PICK,
    ST_STOPPER, ST_TRANSFER, ST_PICK_ARRIVE, ST_PICK_READY
  } seq_step_t;

  localparam int PLAN_ROWS     = 20;
  localparam int PLAN_TYPED    = 3;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 8;
  localparam int STALL_LIMIT   = 2000;

  // status word right after reset, reply flag clear and set
  // {reply, event_number, event, pick rdy, drop rdy, position, open, pick, drop, step}
  localparam logic [32:0] IDLE_QUIET = {1'b0, 7'd0, 1'b0, 1'b0, 1'b0, 16'd1000,
                                        1'b0, 1'b0, 1'b0, ST_IDLE};
  localparam logic [32:0] IDLE_REPLY = {1'b1, 7'd0, 1'b0, 1'b0, 1'b0, 16'd1000,
                                        1'b0, 1'b0, 1'b0, ST_IDLE};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  // sensor_bits[4:0], timer_tick[5], req_type[7:6]
  logic [ctsq_pkg::IN_TDATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  // step[2:0], drop_motor_on[3], pick_motor_on[4], stopper_is_open[5],
  // stopper_position[21:6], drop_rdy_flag[22], pick_rdy_flag[23],
  // event_flag[24], event_number[31:25], reply_flag[32], zeros[39:33]
  logic [ctsq_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  conveyor_transfer_sequencer_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // sequencer model state, starts at its reset values
  seq_step_t   cur_step   = ST_IDLE;
  logic        auto_on    = 1'b0;
  logic        drop_run   = 1'b0;
  logic        pick_run   = 1'b0;
  logic        stop_open  = 1'b0;
  logic [15:0] stop_pos   = 16'd1000;
  logic        drop_rdy   = 1'b0;
  logic        pick_rdy   = 1'b0;
  logic [7:0]  tick_count = '0;
  logic [4:0]  last_snap  = '0;
  logic        snap_seen  = 1'b0;
  logic [6:0]  ev_count   = '0;

  // model copy of the registers
  logic [7:0]  wait_limit   = ctsq_pkg::RST_STOPPER_WAIT;
  logic [7:0]  runout_limit = ctsq_pkg::RST_RUNOUT;
  logic [15:0] open_pos     = ctsq_pkg::RST_OPEN_POS;
  logic [15:0] closed_pos   = ctsq_pkg::RST_CLOSED_POS;

  ctsq_pkg::ctsq_result_t status_q[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int noise_pct      = 0;
  int fail_count     = 0;
  int words_checked  = 0;
  int events_seen    = 0;
  int transfers_done = 0;
  int settings_loaded = 0;
  int stall_cycles   = 0;

  // directed walk: sensor bits are {pick agv, pick stage, buffer, drop stage, drop agv}
  ctsq_pkg::ctsq_item_t plan_in [PLAN_ROWS] = '{
    {ctsq_pkg::REQ_NONE,   1'b0, 5'b00000},  // first pass after reset
    {ctsq_pkg::REQ_STATUS, 1'b1, 5'b11111},
    {ctsq_pkg::REQ_MANUAL, 1'b0, 5'b00000},
    {ctsq_pkg::REQ_AUTO,   1'b1, 5'b00010},  // leave idle
    {ctsq_pkg::REQ_NONE,   1'b0, 5'b00011},  // drop agv still present
    {ctsq_pkg::REQ_NONE,   1'b0, 5'b00010},  // drop stage loaded
    {ctsq_pkg::REQ_NONE,   1'b1, 5'b00000},  // run toward buffer
    {ctsq_pkg::REQ_NONE,   1'b0, 5'b00000},
    {ctsq_pkg::REQ_NONE,   1'b1, 5'b00100},  // buffer reached
    {ctsq_pkg::REQ_NONE,   1'b0, 5'b01000},  // pick stage busy
    {ctsq_pkg::REQ_NONE,   1'b0, 5'b00000},  // pick side clear
    {ctsq_pkg::REQ_NONE,   1'b0, 5'b00100},  // stopper opens, zero wait
    {ctsq_pkg::REQ_NONE,   1'b1, 5'b00100},  // transfer running
    {ctsq_pkg::REQ_NONE,   1'b0, 5'b00000},  // buffer empty, zero runout
    {ctsq_pkg::REQ_NONE,   1'b0, 5'b00010},
    {ctsq_pkg::REQ_NONE,   1'b1, 5'b01010},  // product at pick stage
    {ctsq_pkg::REQ_NONE,   1'b0, 5'b10010},  // pick ready
    {ctsq_pkg::REQ_MANUAL, 1'b0, 5'b10000},
    {ctsq_pkg::REQ_STATUS, 1'b1, 5'b01111},
    {ctsq_pkg::REQ_NONE,   1'b1, 5'b11111}
  };
  ctsq_pkg::ctsq_result_t plan_golden [PLAN_TYPED] = '{IDLE_QUIET, IDLE_REPLY, IDLE_REPLY};

  function automatic void report_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endfunction

  // one control pass: returns the status word and advances the model
  function automatic ctsq_pkg::ctsq_result_t predict_pass(input ctsq_pkg::ctsq_item_t it);
    ctsq_pkg::ctsq_result_t r;
    logic drop_agv, drop_stage, buf_full, pick_stage, pick_agv;
    logic [4:0] snap;
    drop_agv   = it.sensor_bits[ctsq_pkg::SNS_DROP_AGV];
    drop_stage = it.sensor_bits[ctsq_pkg::SNS_DROP_STAGE];
    buf_full   = it.sensor_bits[ctsq_pkg::SNS_BUFFER];
    pick_stage = it.sensor_bits[ctsq_pkg::SNS_PICK_STAGE];
    pick_agv   = it.sensor_bits[ctsq_pkg::SNS_PICK_AGV];

    if (it.timer_tick && tick_count != ctsq_pkg::TICK_MAX) tick_count++;
    if (it.req_type == ctsq_pkg::REQ_AUTO) auto_on = 1'b1;
    else if (it.req_type == ctsq_pkg::REQ_MANUAL) auto_on = 1'b0;

    // snapshot after the command, before ready clearing and step update
    snap = {stop_open, pick_rdy, drop_rdy, pick_run, drop_run};
    r = '0;
    r.step             = cur_step;
    r.drop_motor_on    = drop_run;
    r.pick_motor_on    = pick_run;
    r.stopper_is_open  = stop_open;
    r.stopper_position = stop_pos;
    r.drop_rdy_flag    = drop_rdy;
    r.pick_rdy_flag    = pick_rdy;
    if (!snap_seen || snap != last_snap) begin
      if (snap_seen) begin
        r.event_flag   = 1'b1;
        r.event_number = ev_count;
        ev_count = (ev_count == ctsq_pkg::EVENT_MODULUS - 7'd1) ? 7'd0 : ev_count + 7'd1;
      end
      last_snap = snap;
      snap_seen = 1'b1;
    end
    r.reply_flag = (it.req_type != ctsq_pkg::REQ_NONE);

    // ready flags drop once their condition no longer holds
    if (pick_stage || !pick_agv || pick_run || stop_open) pick_rdy = 1'b0;
    if (!drop_stage || drop_agv || drop_run || stop_open) drop_rdy = 1'b0;

    case (cur_step)
      ST_IDLE: if (auto_on) cur_step = ST_WAIT_DROP;
      ST_WAIT_DROP: begin
        if (drop_stage && !drop_agv && !drop_run && !stop_open) cur_step = ST_TO_BUFFER;
      end
      ST_TO_BUFFER: begin
        if (!buf_full) drop_run = 1'b1;
        else begin
          drop_run = 1'b0;
          cur_step = ST_WAIT_PICK;
        end
      end
      ST_WAIT_PICK: begin
        if (!pick_stage && !pick_agv) begin
          cur_step   = ST_STOPPER;
          tick_count = '0;
        end
      end
      ST_STOPPER: begin
        stop_pos  = open_pos;
        stop_open = 1'b1;
        if (tick_count >= wait_limit) cur_step = ST_TRANSFER;
      end
      ST_TRANSFER: begin
        if (buf_full) begin
          drop_run   = 1'b1;
          pick_run   = 1'b1;
          tick_count = '0;
        end else if (tick_count >= runout_limit) begin
          drop_run  = 1'b0;
          stop_pos  = closed_pos;
          stop_open = 1'b0;
          drop_rdy  = 1'b1;
          cur_step  = ST_PICK_ARRIVE;
        end
      end
      ST_PICK_ARRIVE: begin
        if (pick_stage) begin
          pick_run = 1'b0;
          cur_step = ST_PICK_READY;
        end
      end
      ST_PICK_READY: begin
        pick_rdy = 1'b1;
        cur_step = ST_IDLE;
        transfers_done++;
      end
      default: cur_step = ST_IDLE;
    endcase
    return r;
  endfunction

  // next pass: mostly sensor patterns that move the current step along, some noise
  function automatic ctsq_pkg::ctsq_item_t next_pass();
    ctsq_pkg::ctsq_item_t it;
    int roll;
    it = ctsq_pkg::ctsq_item_t'(8'($urandom_range(255, 0)));
    if ($urandom_range(99, 0) < noise_pct) return it;
    roll = $urandom_range(99, 0);
    if (roll < 8) it.req_type = ctsq_pkg::REQ_STATUS;
    else if (roll < 10) it.req_type = ctsq_pkg::REQ_MANUAL;
    else it.req_type = ctsq_pkg::REQ_NONE;
    case (cur_step)
      ST_IDLE, ST_PICK_READY: begin
        if (cur_step == ST_IDLE && !auto_on) it.req_type = ctsq_pkg::REQ_AUTO;
        // hold both handoffs valid now and then
        if ($urandom_range(1, 0)) begin
          it.sensor_bits[ctsq_pkg::SNS_PICK_STAGE] = 1'b0;
          it.sensor_bits[ctsq_pkg::SNS_PICK_AGV]   = 1'b1;
          it.sensor_bits[ctsq_pkg::SNS_DROP_STAGE] = 1'b1;
          it.sensor_bits[ctsq_pkg::SNS_DROP_AGV]   = 1'b0;
        end
      end
      ST_WAIT_DROP: begin
        it.sensor_bits[ctsq_pkg::SNS_DROP_STAGE] = 1'b1;
        it.sensor_bits[ctsq_pkg::SNS_DROP_AGV]   = 1'b0;
      end
      ST_TO_BUFFER: it.sensor_bits[ctsq_pkg::SNS_BUFFER] = ($urandom_range(99, 0) < 35);
      ST_WAIT_PICK: begin
        it.sensor_bits[ctsq_pkg::SNS_PICK_STAGE] = 1'b0;
        it.sensor_bits[ctsq_pkg::SNS_PICK_AGV]   = 1'b0;
      end
      ST_STOPPER: it.timer_tick = 1'b1;
      ST_TRANSFER: begin
        it.timer_tick = 1'b1;
        // buffer drains once the transfer has started
        it.sensor_bits[ctsq_pkg::SNS_BUFFER] = pick_run ? 1'b0 : ($urandom_range(99, 0) < 70);
      end
      ST_PICK_ARRIVE: it.sensor_bits[ctsq_pkg::SNS_PICK_STAGE] = ($urandom_range(99, 0) < 40);
      default: ;
    endcase
    return it;
  endfunction

  function automatic string field_diffs(input ctsq_pkg::ctsq_result_t want,
                                        input ctsq_pkg::ctsq_result_t got);
    string d;
    d = "";
    if (got.step != want.step) d = {d, " step"};
    if (got.drop_motor_on != want.drop_motor_on) d = {d, " drop_motor_on"};
    if (got.pick_motor_on != want.pick_motor_on) d = {d, " pick_motor_on"};
    if (got.stopper_is_open != want.stopper_is_open) d = {d, " stopper_is_open"};
    if (got.stopper_position != want.stopper_position) d = {d, " stopper_position"};
    if (got.drop_rdy_flag != want.drop_rdy_flag) d = {d, " drop_rdy_flag"};
    if (got.pick_rdy_flag != want.pick_rdy_flag) d = {d, " pick_rdy_flag"};
    if (got.event_flag != want.event_flag) d = {d, " event_flag"};
    if (got.event_number != want.event_number) d = {d, " event_number"};
    if (got.reply_flag != want.reply_flag) d = {d, " reply_flag"};
    return d;
  endfunction

  // push one input word, with random gaps ahead of it
  task automatic send_pass(input ctsq_pkg::ctsq_item_t it, input logic typed,
                           input ctsq_pkg::ctsq_result_t golden);
    ctsq_pkg::ctsq_result_t predicted;
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= it;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = predict_pass(it);
    status_q.push_back(typed ? golden : predicted);
  endtask

  // one register write, valid left high for a following write
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // registers change only with the pipeline drained
  task automatic load_settings(input logic [7:0] wait_val, input logic [7:0] runout_val,
                               input logic [15:0] open_val, input logic [15:0] closed_val);
    while (status_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(ctsq_pkg::CFG_STOPPER_WAIT, {8'd0, wait_val});
    write_reg(ctsq_pkg::CFG_RUNOUT, {8'd0, runout_val});
    write_reg(ctsq_pkg::CFG_OPEN_POS, open_val);
    write_reg(ctsq_pkg::CFG_CLOSED_POS, closed_val);
    cfg_valid <= 1'b0;
    wait_limit   = wait_val;
    runout_limit = runout_val;
    open_pos     = open_val;
    closed_pos   = closed_val;
    settings_loaded++;
  endtask

  task automatic run_random(input int count);
    for (int n = 0; n < count; n++) send_pass(next_pass(), 1'b0, '0);
    in_tvalid <= 1'b0;
  endtask

  // result side stalls
  always @(posedge clk) out_tready <= ($urandom_range(99, 0) >= recv_stall_pct);

  // status word checker
  always @(posedge clk) begin : status_check
    ctsq_pkg::ctsq_result_t got, want;
    string diffs;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[32:0];
      words_checked++;
      if (got.event_flag) events_seen++;
      if (status_q.size() == 0) begin
        report_failure($sformatf("status word %h arrived with nothing pending", out_tdata));
      end else begin
        want  = status_q.pop_front();
        diffs = field_diffs(want, got);
        if (out_tdata[39:33] != '0) diffs = {diffs, " padding"};
        if (diffs != "")
          report_failure($sformatf("word %0d mismatch in%s: expected %h got %h",
                                   words_checked, diffs, want, out_tdata));
      end
    end
  end

  // cycles with no word moving on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin : watchdog
    wait (stall_cycles >= STALL_LIMIT);
    $display("conveyor_transfer_sequencer_top test failed");
    $finish;
  end

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed transfer with zero thresholds and servo extremes
    send_idle_pct  = 10;
    recv_stall_pct = 86;
    load_settings(8'd0, 8'd0, 16'd39999, 16'd0);
    for (int i = 0; i < PLAN_ROWS; i++)
      send_pass(plan_in[i], i < PLAN_TYPED, plan_golden[(i < PLAN_TYPED) ? i : 0]);
    in_tvalid <= 1'b0;

    // short random thresholds
    noise_pct = 15;
    load_settings(8'($urandom_range(6, 1)), 8'($urandom_range(4, 0)),
                  16'($urandom_range(39999, 0)), 16'($urandom_range(39999, 0)));
    run_random(200);

    // longest stopper wait, tick counter saturates
    send_idle_pct  = 86;
    recv_stall_pct = 10;
    load_settings(8'd255, 8'd1, ctsq_pkg::RST_OPEN_POS, ctsq_pkg::RST_CLOSED_POS);
    run_random(280);

    // longest runout, clean sequences only so the buffer stays empty long enough
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    noise_pct      = 0;
    load_settings(8'd1, 8'd255, 16'd0, 16'd39999);
    run_random(320);

    noise_pct = 15;
    load_settings(8'($urandom_range(7, 0)), 8'($urandom_range(7, 0)),
                  16'($urandom_range(39999, 0)), 16'($urandom_range(39999, 0)));
    run_random(150);

    while (status_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (status_q.size() != 0)
      report_failure($sformatf("%0d status words never arrived", status_q.size()));

    $display("%0d status words checked under %0d register settings", words_checked,
             settings_loaded);
    $display("%0d events reported, %0d transfers completed, %0d mismatches", events_seen,
             transfers_done, fail_count);
    if (fail_count == 0)
      $display("conveyor_transfer_sequencer_top test passed");
    else
      $display("conveyor_transfer_sequencer_top test failed");
    $finish;
  end

endmodule

// ----- sim.f -----
sv/ctsq_pkg.sv
sv/ctsq_cfg_regs.sv
sv/ctsq_seq_core.sv
sv/conveyor_transfer_sequencer_top.sv
sim/conveyor_transfer_sequencer_top_tb.sv
